// ===== design/gtn_pkg.sv =====
// shared types and constants for the grid / torus neighbour generator
// depends on nothing; imported by every module of the block
package gtn_pkg;

	// default cap on each grid dimension
	localparam int MAX_DIM_DEF = 1024;

	// field widths
	localparam int COORD_W = 10;
	localparam int DIM_W   = 11;
	localparam int VALUE_W = 31;
	localparam int DIR_W   = 3;
	localparam int CIDX_W  = 3;

	// queue between the front and back parts
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// configuration register indexes
	localparam logic [CIDX_W-1:0] CFG_DIM_X      = 3'd0;
	localparam logic [CIDX_W-1:0] CFG_DIM_Y      = 3'd1;
	localparam logic [CIDX_W-1:0] CFG_DIM_Z      = 3'd2;
	localparam logic [CIDX_W-1:0] CFG_INDEX_BASE = 3'd3;
	localparam logic [CIDX_W-1:0] CFG_TORUS_MODE = 3'd4;

	// neighbour sides
	localparam logic [DIR_W-1:0] DIR_ZM = 3'd0;
	localparam logic [DIR_W-1:0] DIR_YM = 3'd1;
	localparam logic [DIR_W-1:0] DIR_XM = 3'd2;
	localparam logic [DIR_W-1:0] DIR_XP = 3'd3;
	localparam logic [DIR_W-1:0] DIR_YP = 3'd4;
	localparam logic [DIR_W-1:0] DIR_ZP = 3'd5;

	// result kinds
	localparam logic KIND_DEGREE   = 1'b0;
	localparam logic KIND_NEIGHBOR = 1'b1;

	// one classified vertex, as handed from front to back
	typedef struct packed {
		logic               err;       // coordinate out of range
		logic [2:0]         cnt;       // degree
		logic [5:0]         has;       // neighbour present, by side
		logic [2:0]         lo_wrap;   // -1 side wraps, by axis x,y,z
		logic [2:0]         hi_wrap;   // +1 side wraps, by axis x,y,z
		logic [VALUE_W-1:0] vnum;      // own vertex number incl. base
		logic [DIM_W-1:0]   dx;        // x stride for y neighbours
		logic [21:0]        plane;     // dx*dy, stride for z neighbours
		logic [21:0]        ywrap;     // (dy-1)*dx
		logic [VALUE_W-1:0] zwrap;     // (dz-1)*dx*dy, reduced
	} gtn_entry_t;

endpackage

// ===== design/gtn_front.sv =====
// front part: takes vertex coordinates, checks range, works out the
// neighbour mask and the strides over three pipeline stages
// depends on gtn_pkg
module gtn_front import gtn_pkg::*; #(
	parameter int MAX_DIM = MAX_DIM_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [COORD_W-1:0]  coord_x,
	input  logic [COORD_W-1:0]  coord_y,
	input  logic [COORD_W-1:0]  coord_z,
	input  logic [DIM_W-1:0]    dim_x,
	input  logic [DIM_W-1:0]    dim_y,
	input  logic [DIM_W-1:0]    dim_z,
	input  logic                index_base,
	input  logic                torus_mode,
	input  logic                q_full,
	output logic                q_push,
	output gtn_entry_t          q_entry
);

	localparam logic [DIM_W-1:0] DIM_CAP =
		(MAX_DIM >= (1 << DIM_W) - 1) ? {DIM_W{1'b1}} : DIM_W'(MAX_DIM);

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
		return (d > DIM_CAP) ? DIM_CAP : d;
	endfunction

	logic adv;

	// stage 1: captured coordinates and effective dimensions
	logic                     v_s1;
	logic [2:0][COORD_W-1:0]  c_s1;
	logic [2:0][DIM_W-1:0]    d_s1;
	logic                     base_s1;
	logic                     torus_s1;

	// stage 2: classification and first products
	logic                     v_s2;
	logic                     err_s2;
	logic [2:0]               cnt_s2;
	logic [5:0]               has_s2;
	logic [2:0]               lo_wrap_s2;
	logic [2:0]               hi_wrap_s2;
	logic [20:0]              m1_s2;
	logic [21:0]              plane_s2;
	logic [21:0]              ywrap_s2;
	logic [COORD_W-1:0]       x_s2;
	logic [COORD_W-1:0]       y_s2;
	logic [DIM_W-1:0]         dx_s2;
	logic [DIM_W-1:0]         dz_s2;
	logic                     base_s2;

	// stage 3: finished entry
	logic                     v_s3;
	gtn_entry_t               ent_s3;

	logic                     err_c;
	logic [2:0]               cnt_c;
	logic [5:0]               has_c;
	logic [2:0]               lo_wrap_c;
	logic [2:0]               hi_wrap_c;
	logic [DIM_W-1:0]         c1;
	logic [21:0]              sum_c;
	logic [32:0]              vprod_c;
	logic [32:0]              zprod_c;

	assign adv      = !(v_s3 && q_full);
	assign in_stall = !adv;
	assign q_push   = v_s3 && !q_full;
	assign q_entry  = ent_s3;

	// per axis range check and neighbour presence
	always_comb begin
		err_c     = 1'b0;
		cnt_c     = 3'd0;
		has_c     = 6'd0;
		lo_wrap_c = 3'd0;
		hi_wrap_c = 3'd0;
		c1        = '0;
		for (int i = 0; i < 3; i++) begin
			c1 = {1'b0, c_s1[i]} + DIM_W'(1);
			if ({1'b0, c_s1[i]} >= d_s1[i])
				err_c = 1'b1;
			if (torus_s1) begin
				has_c[2-i] = d_s1[i] > DIM_W'(2);
				has_c[3+i] = d_s1[i] > DIM_W'(1);
			end else begin
				has_c[2-i] = c_s1[i] != '0;
				has_c[3+i] = c1 != d_s1[i];
			end
			lo_wrap_c[i] = torus_s1 && (c_s1[i] == '0);
			hi_wrap_c[i] = torus_s1 && (c1 == d_s1[i]);
		end
		for (int j = 0; j < 6; j++)
			cnt_c = cnt_c + {2'd0, has_c[j]};
	end

	// own vertex number and the z wrap stride
	always_comb begin
		sum_c   = {1'b0, m1_s2} + {12'd0, y_s2};
		vprod_c = {11'd0, sum_c} * {22'd0, dx_s2};
		zprod_c = {11'd0, plane_s2} * {22'd0, dz_s2 - DIM_W'(1)};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			c_s1     <= {coord_z, coord_y, coord_x};
			d_s1     <= {clamp_dim(dim_z), clamp_dim(dim_y), clamp_dim(dim_x)};
			base_s1  <= index_base;
			torus_s1 <= torus_mode;

			err_s2     <= err_c;
			cnt_s2     <= cnt_c;
			has_s2     <= has_c;
			lo_wrap_s2 <= lo_wrap_c;
			hi_wrap_s2 <= hi_wrap_c;
			m1_s2      <= {11'd0, c_s1[2]} * {10'd0, d_s1[1]};
			plane_s2   <= {11'd0, d_s1[0]} * {11'd0, d_s1[1]};
			ywrap_s2   <= {11'd0, d_s1[1] - DIM_W'(1)} * {11'd0, d_s1[0]};
			x_s2       <= c_s1[0];
			y_s2       <= c_s1[1];
			dx_s2      <= d_s1[0];
			dz_s2      <= d_s1[2];
			base_s2    <= base_s1;

			ent_s3.err     <= err_s2;
			ent_s3.cnt     <= cnt_s2;
			ent_s3.has     <= has_s2;
			ent_s3.lo_wrap <= lo_wrap_s2;
			ent_s3.hi_wrap <= hi_wrap_s2;
			ent_s3.vnum    <= vprod_c[VALUE_W-1:0] + {21'd0, x_s2} + {30'd0, base_s2};
			ent_s3.dx      <= dx_s2;
			ent_s3.plane   <= plane_s2;
			ent_s3.ywrap   <= ywrap_s2;
			ent_s3.zwrap   <= zprod_c[VALUE_W-1:0];
		end
	end

endmodule

// ===== design/gtn_fifo.sv =====
// short queue of classified vertices between front and back parts
// depends on gtn_pkg
module gtn_fifo import gtn_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  gtn_entry_t  wdata,
	input  logic        pop,
	output gtn_entry_t  head,
	output logic        full,
	output logic        empty
);

	gtn_entry_t          mem_q [QDEPTH];
	logic [QPTR_W-1:0]   wptr_q;
	logic [QPTR_W-1:0]   rptr_q;
	logic [QCNT_W-1:0]   cnt_q;

	assign full  = cnt_q == QCNT_W'(QDEPTH);
	assign empty = cnt_q == '0;
	assign head  = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push)
				wptr_q <= wptr_q + QPTR_W'(1);
			if (pop)
				rptr_q <= rptr_q + QPTR_W'(1);
			if (push && !pop)
				cnt_q <= cnt_q + QCNT_W'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - QCNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wptr_q] <= wdata;
	end

endmodule

// ===== design/gtn_back.sv =====
// back part: walks the queued vertex, one result per cycle while the output is not stalled,
// into the output register; depends on gtn_pkg
module gtn_back import gtn_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  gtn_entry_t          head,
	input  logic                q_empty,
	output logic                q_pop,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                result_kind,
	output logic [VALUE_W-1:0]  value,
	output logic [DIR_W-1:0]    direction,
	output logic                coord_error,
	output logic                last
);

	logic                nb_phase_q;
	logic [5:0]          rem_q;
	logic                out_valid_q;
	logic                kind_q;
	logic [VALUE_W-1:0]  value_q;
	logic [DIR_W-1:0]    dir_q;
	logic                err_q;
	logic                last_q;

	logic                load;
	logic                deg_last;
	logic [DIR_W-1:0]    pick;
	logic [5:0]          pick_oh;
	logic [5:0]          rem_after;
	logic [VALUE_W-1:0]  mag;
	logic                neg;
	logic [VALUE_W-1:0]  nb_val;
	logic [DIM_W-1:0]    dxm1;

	assign load     = !out_valid_q || !out_stall;
	assign deg_last = head.err || (head.has == '0);
	assign q_pop    = load && !q_empty && (nb_phase_q ? (rem_after == '0) : deg_last);

	// lowest remaining side goes next
	always_comb begin
		pick    = DIR_ZM;
		pick_oh = 6'd0;
		for (int i = 5; i >= 0; i--) begin
			if (rem_q[i]) begin
				pick    = DIR_W'(i);
				pick_oh = 6'd1 << i;
			end
		end
		rem_after = rem_q & ~pick_oh;
	end

	// step from the own vertex number to the neighbour
	always_comb begin
		dxm1 = head.dx - DIM_W'(1);
		mag  = '0;
		neg  = 1'b0;
		unique case (pick)
			DIR_ZM: begin
				mag = head.lo_wrap[2] ? head.zwrap : {9'd0, head.plane};
				neg = !head.lo_wrap[2];
			end
			DIR_YM: begin
				mag = head.lo_wrap[1] ? {9'd0, head.ywrap} : {20'd0, head.dx};
				neg = !head.lo_wrap[1];
			end
			DIR_XM: begin
				mag = head.lo_wrap[0] ? {20'd0, dxm1} : VALUE_W'(1);
				neg = !head.lo_wrap[0];
			end
			DIR_XP: begin
				mag = head.hi_wrap[0] ? {20'd0, dxm1} : VALUE_W'(1);
				neg = head.hi_wrap[0];
			end
			DIR_YP: begin
				mag = head.hi_wrap[1] ? {9'd0, head.ywrap} : {20'd0, head.dx};
				neg = head.hi_wrap[1];
			end
			DIR_ZP: begin
				mag = head.hi_wrap[2] ? head.zwrap : {9'd0, head.plane};
				neg = head.hi_wrap[2];
			end
			default: begin
				mag = '0;
				neg = 1'b0;
			end
		endcase
		nb_val = neg ? head.vnum - mag : head.vnum + mag;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			nb_phase_q  <= 1'b0;
			rem_q       <= '0;
		end else if (load) begin
			out_valid_q <= !q_empty;
			if (!q_empty) begin
				if (!nb_phase_q) begin
					if (!deg_last) begin
						nb_phase_q <= 1'b1;
						rem_q      <= head.has;
					end
				end else begin
					rem_q <= rem_after;
					if (rem_after == '0)
						nb_phase_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && !q_empty) begin
			if (!nb_phase_q) begin
				kind_q  <= KIND_DEGREE;
				value_q <= head.err ? '0 : {28'd0, head.cnt};
				dir_q   <= DIR_ZM;
				err_q   <= head.err;
				last_q  <= deg_last;
			end else begin
				kind_q  <= KIND_NEIGHBOR;
				value_q <= nb_val;
				dir_q   <= pick;
				err_q   <= 1'b0;
				last_q  <= rem_after == '0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign result_kind = kind_q;
	assign value       = value_q;
	assign direction   = dir_q;
	assign coord_error = err_q;
	assign last        = last_q;

endmodule

// ===== design/grid_torus_neighbor_gen.sv =====
// 3d grid / torus neighbour generator, top level
// holds the configuration registers and joins front, queue and back
// depends on gtn_pkg, gtn_front, gtn_fifo, gtn_back
//
// usage
//   configuration: write dim_x, dim_y, dim_z, index_base and torus_mode over
//   the cfg channel (cfg_index 0 to 4, cfg_data); cfg_ready is always high,
//   a transfer with any other index is ignored; write only while idle
//   input: one vertex (coord_x, coord_y, coord_z) per transfer on in_valid /
//   in_stall; a new vertex may be taken every cycle while the queue has room
//   output: per vertex first a degree result, then one result per neighbour
//   in side order z-1, y-1, x-1, x+1, y+1, z+1, last marking the final one;
//   an out-of-range coordinate gives a single result with coord_error set
//   path: a vertex passes the three front stages and a queue slot, then its
//   first result is offered from the output register
//   throughput: one result per cycle on the output while out_stall is low, so
//   a vertex gives 1 to 7 results there, the back part stepping one side per
//   cycle; the front runs ahead by up to the queue depth plus three stages
//   stall: a stalled output holds its payload; the queue fills, then
//   in_stall rises until the back part frees a slot
//   reset: dims go to 1, base and torus mode to 0, queue and pipeline empty
module grid_torus_neighbor_gen import gtn_pkg::*; #(
	parameter int MAX_DIM = MAX_DIM_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	// configuration writes
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [CIDX_W-1:0]   cfg_index,
	input  logic [DIM_W-1:0]    cfg_data,
	// vertex input
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [COORD_W-1:0]  coord_x,
	input  logic [COORD_W-1:0]  coord_y,
	input  logic [COORD_W-1:0]  coord_z,
	// result output
	output logic                out_valid,
	input  logic                out_stall,
	output logic                result_kind,
	output logic [VALUE_W-1:0]  value,
	output logic [DIR_W-1:0]    direction,
	output logic                coord_error,
	output logic                last
);

	logic [DIM_W-1:0]  dim_x_q;
	logic [DIM_W-1:0]  dim_y_q;
	logic [DIM_W-1:0]  dim_z_q;
	logic              index_base_q;
	logic              torus_mode_q;

	logic              q_push;
	logic              q_pop;
	logic              q_full;
	logic              q_empty;
	gtn_entry_t        q_wdata;
	gtn_entry_t        q_head;

	// register file is always ready to take a write
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_x_q      <= DIM_W'(1);
			dim_y_q      <= DIM_W'(1);
			dim_z_q      <= DIM_W'(1);
			index_base_q <= 1'b0;
			torus_mode_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_DIM_X:      dim_x_q      <= cfg_data;
				CFG_DIM_Y:      dim_y_q      <= cfg_data;
				CFG_DIM_Z:      dim_z_q      <= cfg_data;
				CFG_INDEX_BASE: index_base_q <= cfg_data[0];
				CFG_TORUS_MODE: torus_mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// classify and compute strides
	gtn_front #(
		.MAX_DIM (MAX_DIM)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.coord_x    (coord_x),
		.coord_y    (coord_y),
		.coord_z    (coord_z),
		.dim_x      (dim_x_q),
		.dim_y      (dim_y_q),
		.dim_z      (dim_z_q),
		.index_base (index_base_q),
		.torus_mode (torus_mode_q),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_entry    (q_wdata)
	);

	// decouples the front from output stalls
	gtn_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.head   (q_head),
		.full   (q_full),
		.empty  (q_empty)
	);

	// one result per cycle into the output register while the output is not stalled
	gtn_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (q_head),
		.q_empty     (q_empty),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.result_kind (result_kind),
		.value       (value),
		.direction   (direction),
		.coord_error (coord_error),
		.last        (last)
	);

endmodule
